[rtl/core/bfpf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bfpf_pkg;

    localparam int MAX_CAPTURE_BYTES = 65535;

    typedef enum logic [1:0] {
        LINK_ETH  = 2'd0,
        LINK_RAW  = 2'd1,
        LINK_PPP  = 2'd2,
        LINK_NONE = 2'd3
    } t_link;

    localparam logic [15:0] ET_IPV4     = 16'h0800;
    localparam logic [15:0] ET_IPV6     = 16'h86dd;
    localparam logic [15:0] ET_PPPOE    = 16'h8864;
    localparam logic [7:0]  PPP_ALL     = 8'hff;
    localparam logic [7:0]  PPP_IPV4    = 8'h21;
    localparam logic [7:0]  PPP_IPV6    = 8'h57;
    localparam logic [7:0]  PROTO_TCP   = 8'd6;
    localparam logic [7:0]  PROTO_UDP   = 8'd17;
    localparam logic [7:0]  PROTO_6IN4  = 8'd41;
    localparam logic [3:0]  IP_VER4     = 4'd4;
    localparam logic [3:0]  IP_VER6     = 4'd6;
    localparam logic [15:0] FRAG_DF     = 16'h4000;
    localparam logic [7:0]  ETH_HDR_LEN = 8'd14;
    localparam logic [7:0]  PPPOE_END   = 8'd20;

    // Header fields picked out of the byte stream
    typedef struct packed {
        logic [15:0]  eth_type;
        logic [7:0]   pppoe_code;
        logic         ppp_ff;
        logic [7:0]   ppp_prot;
        logic [7:0]   ppp_prot2;
        logic [7:0]   ip_b0;
        logic [15:0]  ip_tot;
        logic [15:0]  ip_frag;
        logic [7:0]   ip_proto;
        logic [63:0]  v4_addr;
        logic [15:0]  v6_plen;
        logic [7:0]   v6_nxt;
        logic [255:0] v6_addr;
        logic [47:0]  tp4;
        logic [47:0]  tp6;
    } t_hdr;

    typedef struct packed {
        logic [7:0] base;
        logic       v6;
    } t_link_dec;

    // Offset of the IP header and its family as the link layer announces it
    function automatic t_link_dec f_link_dec(input t_link link, input t_hdr f);
        t_link_dec d;
        logic [2:0] hl;
        logic       ppp_v6;
        hl     = (f.ppp_ff ? 3'd2 : 3'd0) + (f.ppp_prot[0] ? 3'd1 : 3'd2);
        ppp_v6 = (f.ppp_prot == PPP_IPV6) || (f.ppp_prot == 8'h00 && f.ppp_prot2 == PPP_IPV6);
        d.base = 8'd0;
        d.v6   = 1'b0;
        case (link)
            LINK_ETH: begin
                if (f.eth_type == ET_IPV4) begin
                    d.base = ETH_HDR_LEN;
                end else if (f.eth_type == ET_IPV6) begin
                    d.base = ETH_HDR_LEN;
                    d.v6   = 1'b1;
                end else begin
                    d.base = PPPOE_END + {5'd0, hl};
                    d.v6   = ppp_v6;
                end
            end
            LINK_PPP: begin
                d.base = {5'd0, hl};
                d.v6   = ppp_v6;
            end
            default: begin
                d.base = 8'd0;
                d.v6   = 1'b0;
            end
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

[rtl/core/bfpf_capture.sv]
`timescale 1ns / 1ps
`default_nettype none

module bfpf_capture #(
    parameter int P_MAX_BYTES = bfpf_pkg::MAX_CAPTURE_BYTES,
    localparam int POS_W = $clog2(P_MAX_BYTES + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire bfpf_pkg::t_link      i_link,
    input  wire logic                 i_en,
    input  wire logic [7:0]           i_byte,
    input  wire logic                 i_last,
    output bfpf_pkg::t_hdr            o_fields,
    output logic [POS_W-1:0]          o_caplen
);

    localparam logic [POS_W-1:0] MAX_V = POS_W'(P_MAX_BYTES);

    logic [POS_W-1:0]     r_pos;
    logic [39:0]          r_sh;
    bfpf_pkg::t_hdr       r_f;
    bfpf_pkg::t_hdr       n_f;
    bfpf_pkg::t_link_dec  dec;
    logic [16:0]          pos17;
    logic                 lo;
    logic [8:0]           p9;
    logic [8:0]           base9;
    logic [8:0]           ihl9;
    logic [8:0]           b6;
    logic [8:0]           t4;
    logic [8:0]           t6;
    logic [8:0]           pb;

    assign pos17    = 17'(r_pos);
    assign lo       = (pos17[16:8] == 9'd0);
    assign p9       = {1'b0, pos17[7:0]};
    assign o_caplen = (r_pos == MAX_V) ? MAX_V : r_pos + POS_W'(1);
    assign o_fields = n_f;

    always_comb begin
        dec   = bfpf_pkg::f_link_dec(i_link, r_f);
        base9 = {1'b0, dec.base};
        ihl9  = {3'd0, r_f.ip_b0[3:0], 2'b00};
        b6    = (dec.v6 || r_f.ip_b0[7:4] == bfpf_pkg::IP_VER6) ? base9 : base9 + ihl9;
        t4    = base9 + ihl9;
        t6    = b6 + 9'd40;
        pb    = (i_link == bfpf_pkg::LINK_PPP) ? 9'd0 : {1'b0, bfpf_pkg::PPPOE_END};
        n_f   = r_f;
        if (i_en && lo) begin
            if (p9 == 9'd12) n_f.eth_type[15:8] = i_byte;
            if (p9 == 9'd13) n_f.eth_type[7:0]  = i_byte;
            if (p9 == 9'd15) n_f.pppoe_code     = i_byte;
            // PPP: optional address/control pair, then 1- or 2-byte protocol
            if (p9 == pb) begin
                n_f.ppp_ff = (i_byte == bfpf_pkg::PPP_ALL);
                if (i_byte != bfpf_pkg::PPP_ALL) n_f.ppp_prot = i_byte;
            end
            if (p9 == pb + 9'd1 && !r_f.ppp_ff) n_f.ppp_prot2 = i_byte;
            if (p9 == pb + 9'd2 && r_f.ppp_ff)  n_f.ppp_prot  = i_byte;
            if (p9 == pb + 9'd3 && r_f.ppp_ff)  n_f.ppp_prot2 = i_byte;
            // IPv4 header
            if (p9 == base9)          n_f.ip_b0          = i_byte;
            if (p9 == base9 + 9'd2)   n_f.ip_tot[15:8]   = i_byte;
            if (p9 == base9 + 9'd3)   n_f.ip_tot[7:0]    = i_byte;
            if (p9 == base9 + 9'd6)   n_f.ip_frag[15:8]  = i_byte;
            if (p9 == base9 + 9'd7)   n_f.ip_frag[7:0]   = i_byte;
            if (p9 == base9 + 9'd9)   n_f.ip_proto       = i_byte;
            if (p9 >= base9 + 9'd12 && p9 <= base9 + 9'd19)
                n_f.v4_addr = {r_f.v4_addr[55:0], i_byte};
            // IPv6 header, outer or carried in IPv4
            if (p9 == b6 + 9'd4)      n_f.v6_plen[15:8]  = i_byte;
            if (p9 == b6 + 9'd5)      n_f.v6_plen[7:0]   = i_byte;
            if (p9 == b6 + 9'd6)      n_f.v6_nxt         = i_byte;
            if (p9 >= b6 + 9'd8 && p9 <= b6 + 9'd39)
                n_f.v6_addr = {r_f.v6_addr[247:0], i_byte};
            // Ports and UDP length: snapshot the last six bytes
            if (p9 == t4 + 9'd5)      n_f.tp4 = {r_sh, i_byte};
            if (p9 == t6 + 9'd5)      n_f.tp6 = {r_sh, i_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_en) begin
            if (i_last) begin
                r_pos <= '0;
            end else if (r_pos != MAX_V) begin
                r_pos <= r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f  <= n_f;
            r_sh <= {r_sh[31:0], i_byte};
        end
    end

endmodule

`default_nettype wire

[rtl/core/bidirectional_flow_packet_filter.sv]
// Five-tuple flow filter over a captured byte stream.
// Input channel (i_valid/o_ready): one captured byte per transaction, with
// i_last_byte marking the final byte of a packet. The link type register
// (i_cfg_we/i_cfg_wdata) selects Ethernet, raw IP, PPP or reject-all.
// Output channel (o_valid/i_ready): one verdict per packet, carrying
// o_packet_keep and o_flow_learned_now; bytes that do not end a packet give
// nothing.
// Throughput: one byte per cycle, except that a packet's last byte waits while a verdict is
// not yet taken. Header fields are captured as bytes pass; once its last byte is accepted,
// a packet's verdict goes through the input register, then field capture plus verdict into the output register.
// The first packet that parses to TCP or UDP becomes the flow; later packets
// are kept when they match it in either direction.
// Reset clears the link type to Ethernet, forgets the flow and restarts the
// byte count. While the receiver stalls with a verdict waiting, the byte in
// the input register is still absorbed unless it ends a packet; then input
// is held until the verdict is taken.
`timescale 1ns / 1ps
`default_nettype none

module bidirectional_flow_packet_filter #(
    parameter int MAX_CAPTURE_BYTES = bfpf_pkg::MAX_CAPTURE_BYTES
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_wdata,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic            o_packet_keep,
    output logic            o_flow_learned_now
);

    localparam int POS_W = $clog2(MAX_CAPTURE_BYTES + 1);

    bfpf_pkg::t_link     r_link;
    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_in_last;
    logic                r_flow_def;
    logic                r_flow_v6;
    logic                r_flow_udp;
    logic [127:0]        r_lsrc;
    logic [127:0]        r_ldst;
    logic [31:0]         r_lports;

    logic                proc;
    logic                verdict;
    bfpf_pkg::t_hdr      cf;
    logic [POS_W-1:0]    caplen;
    bfpf_pkg::t_link_dec dec;
    logic [16:0]         c17, b17, l17, tot17, ihl17, tlen4, len6, tlen, ulen17;
    logic                ppp_v4, ppp_ok, link_ok, precheck, prefail, v4_ok;
    logic                use_v6, ip_ok, udp, tr_ok, parse_ok, learn, fwd, rev, keep;
    logic [47:0]         snap;
    logic [127:0]        src, dst;
    logic [15:0]         sp, dp;

    assign proc    = r_in_valid && (!r_in_last || !o_valid || i_ready);
    assign o_ready = !r_in_valid || proc;
    assign verdict = proc && r_in_last;

    bfpf_capture #(
        .P_MAX_BYTES (MAX_CAPTURE_BYTES)
    ) u_capture (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_link   (r_link),
        .i_en     (proc),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_fields (cf),
        .o_caplen (caplen)
    );

    always_comb begin
        dec    = bfpf_pkg::f_link_dec(r_link, cf);
        c17    = 17'(caplen);
        b17    = 17'(dec.base);
        l17    = c17 - b17;
        tot17  = 17'(cf.ip_tot);
        ihl17  = 17'({cf.ip_b0[3:0], 2'b00});
        tlen4  = tot17 - ihl17;
        ppp_v4 = (cf.ppp_prot == bfpf_pkg::PPP_IPV4) ||
                 (cf.ppp_prot == 8'h00 && cf.ppp_prot2 == bfpf_pkg::PPP_IPV4);
        ppp_ok = (b17 <= c17) && (ppp_v4 || dec.v6);
        case (r_link)
            bfpf_pkg::LINK_ETH: begin
                precheck = 1'b1;
                if (cf.eth_type == bfpf_pkg::ET_IPV4 || cf.eth_type == bfpf_pkg::ET_IPV6) begin
                    link_ok = (c17 >= 17'd14);
                end else if (cf.eth_type == bfpf_pkg::ET_PPPOE) begin
                    link_ok = (c17 >= 17'd20) && (cf.pppoe_code == 8'h00) && ppp_ok;
                end else begin
                    link_ok = 1'b0;
                end
            end
            bfpf_pkg::LINK_RAW: begin
                precheck = 1'b0;
                link_ok  = 1'b1;
            end
            bfpf_pkg::LINK_PPP: begin
                precheck = 1'b1;
                link_ok  = ppp_ok;
            end
            default: begin
                precheck = 1'b0;
                link_ok  = 1'b0;
            end
        endcase
        prefail = precheck && r_flow_def && (dec.v6 != r_flow_v6);

        v4_ok = (b17 + 17'd20 <= c17) && (tot17 <= l17) && (ihl17 <= tot17) &&
                (cf.ip_frag == 16'h0000 || cf.ip_frag == bfpf_pkg::FRAG_DF);

        use_v6 = 1'b0;
        ip_ok  = 1'b0;
        len6   = l17;
        udp    = (cf.ip_proto == bfpf_pkg::PROTO_UDP);
        tlen   = tlen4;
        snap   = cf.tp4;
        if (dec.v6) begin
            use_v6 = 1'b1;
            ip_ok  = 1'b1;
        end else if (cf.ip_b0[7:4] == bfpf_pkg::IP_VER4) begin
            if (cf.ip_proto == bfpf_pkg::PROTO_TCP || cf.ip_proto == bfpf_pkg::PROTO_UDP) begin
                ip_ok = v4_ok;
            end else if (cf.ip_proto == bfpf_pkg::PROTO_6IN4) begin
                use_v6 = 1'b1;
                ip_ok  = v4_ok;
                len6   = tlen4;
            end
        end else if (cf.ip_b0[7:4] == bfpf_pkg::IP_VER6) begin
            use_v6 = 1'b1;
            ip_ok  = 1'b1;
        end
        if (use_v6) begin
            ip_ok = ip_ok && (17'd40 + 17'(cf.v6_plen) <= len6) &&
                    (cf.v6_nxt == bfpf_pkg::PROTO_TCP || cf.v6_nxt == bfpf_pkg::PROTO_UDP);
            udp   = (cf.v6_nxt == bfpf_pkg::PROTO_UDP);
            tlen  = 17'(cf.v6_plen);
            snap  = cf.tp6;
        end

        sp     = snap[47:32];
        dp     = snap[31:16];
        ulen17 = 17'(snap[15:0]);
        tr_ok  = udp ? (tlen >= 17'd8 && tlen >= ulen17) : (tlen >= 17'd20);

        if (use_v6) begin
            src = cf.v6_addr[255:128];
            dst = cf.v6_addr[127:0];
        end else begin
            src = {96'd0, cf.v4_addr[63:32]};
            dst = {96'd0, cf.v4_addr[31:0]};
        end

        parse_ok = link_ok && !prefail && ip_ok && tr_ok;
        learn    = parse_ok && !r_flow_def;
        fwd      = (r_lports == {sp, dp}) && (r_lsrc == src) && (r_ldst == dst);
        rev      = (r_lports == {dp, sp}) && (r_lsrc == dst) && (r_ldst == src);
        keep     = learn || (parse_ok && r_flow_def && (use_v6 == r_flow_v6) &&
                   (udp == r_flow_udp) && (fwd || rev));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link     <= bfpf_pkg::LINK_ETH;
            r_in_valid <= 1'b0;
            o_valid    <= 1'b0;
            r_flow_def <= 1'b0;
            r_flow_v6  <= 1'b0;
            r_flow_udp <= 1'b0;
        end else begin
            if (i_cfg_we) r_link <= bfpf_pkg::t_link'(i_cfg_wdata);
            if (i_valid && o_ready) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (verdict) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
            if (verdict && learn) begin
                r_flow_def <= 1'b1;
                r_flow_v6  <= use_v6;
                r_flow_udp <= udp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
        if (verdict) begin
            o_packet_keep      <= keep;
            o_flow_learned_now <= learn;
        end
        // capture the flow from the packet that defines it
        if (verdict && learn) begin
            r_lsrc   <= src;
            r_ldst   <= dst;
            r_lports <= {sp, dp};
        end
    end

endmodule

`default_nettype wire

[bench/bidirectional_flow_packet_filter_tb.sv]
`timescale 1ns / 1ps

module bidirectional_flow_packet_filter_tb;
    import bfpf_pkg::*;

    typedef logic [7:0] bytes_t[$];

    typedef struct {
        bit keep;
        bit learned;
    } verdict_t;

    localparam int unsigned HDR_WINDOW = 256;
    localparam longint CYCLE_LIMIT = 3000000;

    // Verdict predictor: captures each packet's header window and parses it at the last byte
    class flow_scoreboard;
        t_link        link;
        bit           defined;
        bit           is_v6;
        bit           is_udp;
        bit [63:0]    l_src[2];
        bit [63:0]    l_dst[2];
        bit [31:0]    l_ports;
        bit [63:0]    cur[4];
        bit [31:0]    cur_ports;
        int unsigned  pos;
        bit [7:0]     win[HDR_WINDOW];
        bit           rd_fail;
        int unsigned  rd_lim;
        bit           learned;
        verdict_t     pending[$];
        int           errors;
        int           verdicts;

        function new();
            link     = LINK_ETH;
            defined  = 0;
            is_v6    = 0;
            is_udp   = 0;
            pos      = 0;
            errors   = 0;
            verdicts = 0;
        endfunction

        function bit [31:0] rd8(int unsigned a);
            if (a >= rd_lim || a >= HDR_WINDOW) begin
                rd_fail = 1;
                return 0;
            end
            return {24'd0, win[a]};
        endfunction

        function bit [31:0] rd16(int unsigned a);
            return (rd8(a) << 8) | rd8(a + 1);
        endfunction

        function bit [63:0] rd64(int unsigned a);
            bit [63:0] v;
            v = 0;
            for (int i = 0; i < 8; i++) v = (v << 8) | rd8(a + i);
            return v;
        endfunction

        function bit match_ports(int unsigned base, int unsigned len, bit udp, bit fam6);
            bit [31:0] sp;
            bit [31:0] dp;
            bit fwd;
            bit rev;
            rd_lim = base + len;
            if (udp) begin
                if (len < 8) return 0;
                if (len < rd16(base + 4)) return 0;
            end else if (len < 20) begin
                return 0;
            end
            sp = rd16(base);
            dp = rd16(base + 2);
            if (rd_fail) return 0;
            cur_ports = (sp << 16) | dp;
            if (!defined) begin
                defined  = 1;
                is_udp   = udp;
                is_v6    = fam6;
                l_src[0] = cur[0];
                l_src[1] = cur[1];
                l_dst[0] = cur[2];
                l_dst[1] = cur[3];
                l_ports  = cur_ports;
                learned  = 1;
                return 1;
            end
            if (fam6 != is_v6 || udp != is_udp) return 0;
            fwd = l_ports == cur_ports && l_src[0] == cur[0] && l_src[1] == cur[1]
                  && l_dst[0] == cur[2] && l_dst[1] == cur[3];
            rev = l_ports == ((dp << 16) | sp) && l_src[0] == cur[2] && l_src[1] == cur[3]
                  && l_dst[0] == cur[0] && l_dst[1] == cur[1];
            return fwd || rev;
        endfunction

        function bit parse_v6(int unsigned base, int unsigned len);
            bit [31:0] plen;
            bit [31:0] nxt;
            rd_lim = base + len;
            plen = rd16(base + 4);
            nxt  = rd8(base + 6);
            if (rd_fail || 40 + plen > len) return 0;
            cur[0] = rd64(base + 8);
            cur[1] = rd64(base + 16);
            cur[2] = rd64(base + 24);
            cur[3] = rd64(base + 32);
            if (rd_fail) return 0;
            if (nxt == PROTO_TCP) begin
                if (defined && is_udp) return 0;
                return match_ports(base + 40, plen, 0, 1);
            end
            if (nxt == PROTO_UDP) begin
                if (defined && !is_udp) return 0;
                return match_ports(base + 40, plen, 1, 1);
            end
            return 0;
        endfunction

        function bit parse_v4(int unsigned base, int unsigned len);
            bit [31:0] b0;
            bit [31:0] ihl;
            bit [31:0] tot;
            bit [31:0] frag;
            bit [31:0] proto;
            bit [31:0] src;
            bit [31:0] dst;
            rd_lim = base + len;
            b0 = rd8(base);
            if (rd_fail) return 0;
            if (b0[7:4] != IP_VER4) begin
                if (b0[7:4] == IP_VER6) return parse_v6(base, len);
                return 0;
            end
            ihl   = b0[3:0] * 4;
            tot   = rd16(base + 2);
            frag  = rd16(base + 6);
            proto = rd8(base + 9);
            src   = (rd16(base + 12) << 16) | rd16(base + 14);
            dst   = (rd16(base + 16) << 16) | rd16(base + 18);
            if (rd_fail || tot > len) return 0;
            if (frag != 0 && frag != FRAG_DF) return 0;
            if (ihl > tot) return 0;
            cur[0] = 0;
            cur[1] = {32'd0, src};
            cur[2] = 0;
            cur[3] = {32'd0, dst};
            if (proto == PROTO_TCP) begin
                if (defined && is_udp) return 0;
                return match_ports(base + ihl, tot - ihl, 0, 0);
            end
            if (proto == PROTO_UDP) begin
                if (defined && !is_udp) return 0;
                return match_ports(base + ihl, tot - ihl, 1, 0);
            end
            if (proto == PROTO_6IN4) begin
                if (defined && !is_v6) return 0;
                return parse_v6(base + ihl, tot - ihl);
            end
            return 0;
        endfunction

        function bit parse_ppp(int unsigned base, int unsigned len);
            int unsigned off;
            int unsigned hl;
            bit [31:0] prot;
            bit [31:0] pp;
            rd_lim = base + len;
            off  = (rd8(base) == PPP_ALL) ? 2 : 0;
            prot = rd8(base + off);
            if (prot[0]) begin
                pp = prot;
                hl = off + 1;
            end else begin
                pp = rd16(base + off);
                hl = off + 2;
            end
            if (rd_fail || hl > len) return 0;
            if (pp == PPP_IPV4) begin
                if (defined && is_v6) return 0;
                return parse_v4(base + hl, len - hl);
            end
            if (pp == PPP_IPV6) begin
                if (defined && !is_v6) return 0;
                return parse_v6(base + hl, len - hl);
            end
            return 0;
        endfunction

        function bit parse_eth(int unsigned len);
            bit [31:0] et;
            rd_lim = len;
            if (len < 14) return 0;
            et = rd16(12);
            if (et == ET_IPV4) begin
                if (defined && is_v6) return 0;
                return parse_v4(14, len - 14);
            end
            if (et == ET_IPV6) begin
                if (defined && !is_v6) return 0;
                return parse_v6(14, len - 14);
            end
            if (et == ET_PPPOE) begin
                if (len - 14 < 6) return 0;
                if (rd8(15) != 0 || rd_fail) return 0;
                return parse_ppp(20, len - 20);
            end
            return 0;
        endfunction

        function void note_byte(bit [7:0] b, bit last);
            int unsigned caplen;
            verdict_t v;
            if (pos < MAX_CAPTURE_BYTES) begin
                if (pos < HDR_WINDOW) win[pos] = b;
                pos++;
            end
            if (!last) return;
            caplen  = pos;
            pos     = 0;
            rd_fail = 0;
            learned = 0;
            case (link)
                LINK_ETH: v.keep = parse_eth(caplen);
                LINK_RAW: v.keep = parse_v4(0, caplen);
                LINK_PPP: v.keep = parse_ppp(0, caplen);
                default:  v.keep = 0;
            endcase
            v.learned = v.keep && learned;
            pending.push_back(v);
        endfunction

        function void check(bit keep, bit lrn);
            verdict_t v;
            verdicts++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected verdict keep=%b learned=%b", $realtime, keep, lrn);
                errors++;
                return;
            end
            v = pending.pop_front();
            if (keep != v.keep) begin
                $display("%0t: packet_keep expected %b actual %b", $realtime, v.keep, keep);
                errors++;
            end
            if (lrn != v.learned) begin
                $display("%0t: flow_learned_now expected %b actual %b",
                         $realtime, v.learned, lrn);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       i_cfg_we = 0;
    logic [1:0] i_cfg_wdata = '0;
    logic       i_valid = 0;
    logic       o_ready;
    logic [7:0] i_data_byte = '0;
    logic       i_last_byte = 0;
    logic       o_valid;
    logic       i_ready = 0;
    logic       o_packet_keep;
    logic       o_flow_learned_now;

    flow_scoreboard sb = new();
    int      tx_idle = 23;
    int      rx_idle = 57;
    longint  cycles = 0;

    bit             flow_v6;
    bit             flow_udp;
    logic [127:0]   flow_src;
    logic [127:0]   flow_dst;
    logic [15:0]    flow_sp;
    logic [15:0]    flow_dp;

    bidirectional_flow_packet_filter u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_data_byte        (i_data_byte),
        .i_last_byte        (i_last_byte),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_packet_keep      (o_packet_keep),
        .o_flow_learned_now (o_flow_learned_now)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Verdict side: check each transaction, then decide whether to stall
    always @(posedge i_clk) begin
        if (o_valid && i_ready) sb.check(o_packet_keep, o_flow_learned_now);
        i_ready <= ($urandom_range(99) >= rx_idle);
    end

    function automatic logic [7:0] rnd8();
        return 8'($urandom);
    endfunction

    function automatic bytes_t build_tp(bit udp, logic [15:0] sp, logic [15:0] dp);
        bytes_t t;
        int n;
        logic [15:0] ulen;
        n = $urandom_range(0, 6);
        t = {sp[15:8], sp[7:0], dp[15:8], dp[7:0]};
        if (udp) begin
            ulen = 16'(8 + n);
            t.push_back(ulen[15:8]);
            t.push_back(ulen[7:0]);
            repeat (2) t.push_back(rnd8());
        end else begin
            repeat (16) t.push_back(rnd8());
        end
        repeat (n) t.push_back(rnd8());
        return t;
    endfunction

    // fam: 0 IPv4, 1 IPv6, 2 IPv6 inside IPv4; dir: 0 forward, 1 reversed, 2 random tuple
    function automatic bytes_t build_ip(int fam, bit udp, int dir, logic [15:0] frag);
        bytes_t q;
        bytes_t tp;
        bytes_t inner;
        logic [127:0] sa;
        logic [127:0] da;
        logic [15:0] sp;
        logic [15:0] dp;
        logic [15:0] len16;
        logic [31:0] s4;
        logic [31:0] d4;
        logic [7:0] proto;
        int ihl;
        sa = flow_src;
        da = flow_dst;
        sp = flow_sp;
        dp = flow_dp;
        if (dir == 1) begin
            sa = flow_dst;
            da = flow_src;
            sp = flow_dp;
            dp = flow_sp;
        end else if (dir == 2) begin
            sa = {$urandom, $urandom, $urandom, $urandom};
            da = {$urandom, $urandom, $urandom, $urandom};
            sp = 16'($urandom);
            dp = 16'($urandom);
        end
        tp = build_tp(udp, sp, dp);
        if (fam != 0) begin
            len16 = 16'(tp.size());
            inner = {8'h60, rnd8(), rnd8(), rnd8(), len16[15:8], len16[7:0],
                     udp ? PROTO_UDP : PROTO_TCP, rnd8()};
            for (int i = 15; i >= 0; i--) inner.push_back(sa[i*8 +: 8]);
            for (int i = 15; i >= 0; i--) inner.push_back(da[i*8 +: 8]);
            foreach (tp[i]) inner.push_back(tp[i]);
            if (fam == 1) return inner;
            s4 = $urandom;
            d4 = $urandom;
            proto = PROTO_6IN4;
        end else begin
            inner = tp;
            s4 = sa[31:0];
            d4 = da[31:0];
            proto = udp ? PROTO_UDP : PROTO_TCP;
        end
        ihl = $urandom_range(5, 6);
        len16 = 16'(ihl * 4 + inner.size());
        q = {{IP_VER4, 4'(ihl)}, rnd8(), len16[15:8], len16[7:0], rnd8(), rnd8(),
             frag[15:8], frag[7:0], rnd8(), proto, rnd8(), rnd8(),
             s4[31:24], s4[23:16], s4[15:8], s4[7:0], d4[31:24], d4[23:16], d4[15:8], d4[7:0]};
        repeat ((ihl - 5) * 4) q.push_back(rnd8());
        foreach (inner[i]) q.push_back(inner[i]);
        return q;
    endfunction

    function automatic bytes_t wrap_ppp(bytes_t ip);
        bytes_t q;
        logic [7:0] prot;
        prot = (ip[0][7:4] == IP_VER6) ? PPP_IPV6 : PPP_IPV4;
        if ($urandom_range(1)) q = {PPP_ALL, 8'h03};
        if ($urandom_range(1)) q.push_back(prot);
        else q = {q, 8'h00, prot};
        foreach (ip[i]) q.push_back(ip[i]);
        return q;
    endfunction

    function automatic bytes_t wrap_link(t_link lk, bytes_t ip, bit pppoe);
        bytes_t q;
        logic [15:0] et;
        if (lk == LINK_RAW) return ip;
        if (lk != LINK_ETH) return wrap_ppp(ip);
        repeat (12) q.push_back(rnd8());
        if (pppoe) begin
            q = {q, ET_PPPOE[15:8], ET_PPPOE[7:0], 8'h11, 8'h00,
                 rnd8(), rnd8(), rnd8(), rnd8()};
            ip = wrap_ppp(ip);
        end else begin
            et = (ip[0][7:4] == IP_VER6) ? ET_IPV6 : ET_IPV4;
            q = {q, et[15:8], et[7:0]};
        end
        foreach (ip[i]) q.push_back(ip[i]);
        return q;
    endfunction

    task automatic send_byte(logic [7:0] b, bit last);
        while ($urandom_range(99) < tx_idle) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid     <= 1;
        i_data_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (!o_ready);
        sb.note_byte(b, last);
    endtask

    task automatic send_pkt(bytes_t q);
        foreach (q[i]) send_byte(q[i], i == q.size() - 1);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        // a byte without a verdict may still sit in the pipeline
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_link(t_link lk);
        drain();
        i_cfg_we    <= 1;
        i_cfg_wdata <= lk;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.link = lk;
    endtask

    function automatic int flow_fam();
        if (!flow_v6) return 0;
        return $urandom_range(1) ? 1 : 2;
    endfunction

    function automatic bytes_t random_pkt(t_link lk);
        bytes_t q;
        int r;
        int fam;
        int dir;
        bit udp;
        r = $urandom_range(99);
        if (r < 8) begin
            repeat ($urandom_range(1, 60)) q.push_back(rnd8());
            return q;
        end
        fam = ($urandom_range(1)) ? flow_fam() : $urandom_range(0, 2);
        udp = ($urandom_range(99) < 85) ? flow_udp : !flow_udp;
        dir = $urandom_range(99);
        dir = (dir < 40) ? 0 : (dir < 80) ? 1 : 2;
        q = wrap_link(lk, build_ip(fam, udp, dir, $urandom_range(1) ? FRAG_DF : 16'h0),
                      $urandom_range(3) == 0);
        if (r < 18) begin
            q[$urandom_range(0, q.size() - 1)] = rnd8();
        end else if (r < 25) begin
            while (q.size() > 1 && $urandom_range(3) != 0) void'(q.pop_back());
        end else if (r < 29) begin
            repeat ($urandom_range(1, 10)) q.push_back(rnd8());
        end
        return q;
    endfunction

    initial begin
        t_link links[9];
        bytes_t q;
        int nbytes;
        int npkts;
        links = '{LINK_ETH, LINK_RAW, LINK_PPP, LINK_NONE, LINK_PPP,
                  LINK_ETH, LINK_RAW, LINK_NONE, LINK_ETH};
        flow_v6  = $urandom_range(1);
        flow_udp = $urandom_range(1);
        flow_src = {$urandom, $urandom, $urandom, $urandom};
        flow_dst = {$urandom, $urandom, $urandom, $urandom};
        flow_sp  = 16'($urandom);
        flow_dp  = 16'($urandom);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;

        // short and truncated headers, then a fragment, before any flow exists
        send_pkt('{8'hff});
        send_pkt('{rnd8(), rnd8(), rnd8(), rnd8(), rnd8(), rnd8(), rnd8(), rnd8(), rnd8()});
        send_pkt(wrap_link(LINK_ETH, build_ip(0, flow_udp, 0, 16'h2000), 0));
        // learn the flow, then follow it both ways
        send_pkt(wrap_link(LINK_ETH, build_ip(flow_fam(), flow_udp, 0, 16'h0), 0));
        send_pkt(wrap_link(LINK_ETH, build_ip(flow_fam(), flow_udp, 1, FRAG_DF), 0));
        send_pkt(wrap_link(LINK_ETH, build_ip(flow_fam(), flow_udp, 0, 16'h0), 1));
        send_pkt(wrap_link(LINK_ETH, build_ip(flow_fam(), flow_udp, 2, 16'h0), 0));
        send_pkt(wrap_link(LINK_ETH, build_ip(flow_fam(), !flow_udp, 0, 16'h0), 0));
        send_pkt(wrap_link(LINK_ETH, build_ip(flow_v6 ? 0 : 1, flow_udp, 0, 16'h0), 1));
        q = wrap_link(LINK_ETH, build_ip(flow_fam(), flow_udp, 1, 16'h0), 0);
        void'(q.pop_back());
        send_pkt(q);
        q = wrap_link(LINK_ETH, build_ip(0, flow_udp, 0, 16'h0), 0);
        q[12] = 8'h88;
        q[13] = 8'h47;
        send_pkt(q);
        // packet longer than the capture limit
        q = wrap_link(LINK_ETH, build_ip(flow_fam(), flow_udp, 0, 16'h0), 0);
        while (q.size() < MAX_CAPTURE_BYTES + 500) q.push_back(rnd8());
        send_pkt(q);

        for (int p = 0; p < 9; p++) begin
            set_link(links[p]);
            tx_idle = (p < 3) ? 23 : (p < 6) ? 57 : 0;
            rx_idle = (p < 3) ? 57 : (p < 6) ? 23 : 0;
            nbytes = 0;
            npkts = 0;
            while (nbytes < 75 || npkts < 8) begin
                q = random_pkt(links[p]);
                send_pkt(q);
                nbytes += q.size();
                npkts++;
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
